/* rtl/core/deque_with_delete_by_value_top_assert.svh */
`ifndef DEQUE_WITH_DELETE_BY_VALUE_TOP_ASSERT_SVH
`define DEQUE_WITH_DELETE_BY_VALUE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DQDEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DQDEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dqdel_pkg.sv */
package dqdel_pkg;

  localparam int DQDEL_CAPACITY   = 16;
  localparam int DQDEL_VALUE_BITS = 32;
  localparam int DQDEL_FUNC_W     = 3;

  typedef enum logic [DQDEL_FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_DELETE     = 3'd3,
    FUNC_CLEAR      = 3'd4
  } dqdel_func_e;

  typedef struct packed {
    logic load_back;
    logic shift_back;
    logic shift_front;
    logic del;
  } dqdel_ctrl_t;

endpackage

/* rtl/core/deque_with_delete_by_value_top.sv */
// double-ended queue of handle words with delete by value
// input beat: s_axis_tuser carries the operation (0 push back, 1 push front,
//   2 pop front, 3 delete value, 4 clear), s_axis_tdata the value
// output beat: one result per input beat with popped value, hit, refused,
//   empty flag and fill count after the operation
// entries sit in a row of cells, front in cell 0; push front and pop shift
//   the whole row by one, delete compares in every cell and the first matching
//   cell and all cells behind it take their neighbor's value, all in the same cycle
// the result is registered and appears in the cycle after the input beat is taken
// throughput: one operation per cycle while the receiver takes each result, set by the single output register
// when the receiver stalls, the result waits in the output register and no
//   further input is taken until it leaves
// reset empties the queue; s_axis_tready stays low while reset is held and
//   until run_q is registered high after release; cell contents are not cleared
module deque_with_delete_by_value_top #(
  parameter int CAPACITY   = dqdel_pkg::DQDEL_CAPACITY,
  parameter int VALUE_BITS = dqdel_pkg::DQDEL_VALUE_BITS,
  parameter int CNT_W      = $clog2(CAPACITY + 1),
  parameter int IN_W       = ((VALUE_BITS + 7) / 8) * 8,
  parameter int OUT_W      = ((VALUE_BITS + 3 + CNT_W + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // item_value
  input  logic [IN_W-1:0]                     s_axis_tdata,
  // func
  input  logic [dqdel_pkg::DQDEL_FUNC_W-1:0]  s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // popped_value, hit, refused, is_empty, fill_count
  output logic [OUT_W-1:0]                    m_axis_tdata
);
  import dqdel_pkg::*;

  logic                  run_q;
  logic                  out_valid_q, out_valid_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [VALUE_BITS-1:0] out_popped_q, out_popped_d;
  logic                  out_hit_q, out_hit_d;
  logic                  out_refused_q, out_refused_d;
  logic [CNT_W-1:0]      out_count_q;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [VALUE_BITS-1:0] item;
  dqdel_func_e           func;
  dqdel_ctrl_t           ctrl;
  logic [VALUE_BITS-1:0] vals [CAPACITY];
  logic                  seen [CAPACITY+1];

  assign item          = s_axis_tdata[VALUE_BITS-1:0];
  assign func          = dqdel_func_e'(s_axis_tuser);
  assign s_axis_tready = run_q && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = count_q == CNT_W'(CAPACITY);
  assign empty         = count_q == '0;
  assign seen[0]       = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] prev_v, next_v;
    if (g == 0) begin : g_first
      assign prev_v = item;
    end else begin : g_mid
      assign prev_v = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_v = vals[g];
    end else begin : g_body
      assign next_v = vals[g+1];
    end
    dqdel_cell #(
      .IDX        (g),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .item_i  (item),
      .prev_i  (prev_v),
      .next_i  (next_v),
      .seen_i  (seen[g]),
      .seen_o  (seen[g+1]),
      .value_o (vals[g])
    );
  end

  always_comb begin
    ctrl          = '0;
    count_d       = count_q;
    out_popped_d  = '0;
    out_hit_d     = 1'b0;
    out_refused_d = 1'b0;
    if (accept) begin
      unique case (func)
        FUNC_PUSH_BACK: begin
          if (full) begin
            out_refused_d = 1'b1;
          end else begin
            ctrl.load_back = 1'b1;
            count_d        = count_q + 1'b1;
          end
        end
        FUNC_PUSH_FRONT: begin
          if (full) begin
            out_refused_d = 1'b1;
          end else begin
            ctrl.shift_back = 1'b1;
            count_d         = count_q + 1'b1;
          end
        end
        FUNC_POP_FRONT: begin
          if (!empty) begin
            ctrl.shift_front = 1'b1;
            out_popped_d     = vals[0];
            out_hit_d        = 1'b1;
            count_d          = count_q - 1'b1;
          end
        end
        FUNC_DELETE: begin
          ctrl.del  = 1'b1;
          out_hit_d = seen[CAPACITY];
          if (seen[CAPACITY]) begin
            count_d = count_q - 1'b1;
          end
        end
        FUNC_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      run_q       <= 1'b1;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_popped_q  <= out_popped_d;
      out_hit_q     <= out_hit_d;
      out_refused_q <= out_refused_d;
      out_count_q   <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_count_q, (out_count_q == '0), out_refused_q,
                                 out_hit_q, out_popped_q});

endmodule

/* rtl/core/dqdel_cell.sv */
module dqdel_cell #(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = dqdel_pkg::DQDEL_VALUE_BITS,
  parameter int CNT_W      = 5
) (
  input  logic                   clk_i,
  input  dqdel_pkg::dqdel_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [VALUE_BITS-1:0]  item_i,
  input  logic [VALUE_BITS-1:0]  prev_i,
  input  logic [VALUE_BITS-1:0]  next_i,
  input  logic                   seen_i,
  output logic                   seen_o,
  output logic [VALUE_BITS-1:0]  value_o
);
  import dqdel_pkg::*;

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  live;
  logic                  match;

  assign live    = CNT_W'(IDX) < count_i;
  assign match   = live && (value_q == item_i);
  assign seen_o  = seen_i | match;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    priority if (ctrl_i.load_back && (count_i == CNT_W'(IDX))) begin
      value_d = item_i;
    end else if (ctrl_i.shift_back) begin
      value_d = prev_i;
    end else if (ctrl_i.shift_front) begin
      value_d = next_i;
    end else if (ctrl_i.del && seen_o) begin
      value_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

/* rtl/core/dqdel_checker.sv */
`include "deque_with_delete_by_value_top_assert.svh"

module dqdel_checker #(
  parameter int CAPACITY   = dqdel_pkg::DQDEL_CAPACITY,
  parameter int VALUE_BITS = dqdel_pkg::DQDEL_VALUE_BITS,
  parameter int CNT_W      = $clog2(CAPACITY + 1),
  parameter int IN_W       = ((VALUE_BITS + 7) / 8) * 8,
  parameter int OUT_W      = ((VALUE_BITS + 3 + CNT_W + 7) / 8) * 8
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [IN_W-1:0]                    s_axis_tdata,
  input logic [dqdel_pkg::DQDEL_FUNC_W-1:0] s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [OUT_W-1:0]                   m_axis_tdata
);
  import dqdel_pkg::*;

  logic [VALUE_BITS-1:0] popped;
  logic                  hit;
  logic                  refused;
  logic                  is_empty;
  logic [CNT_W-1:0]      fill;
  logic                  in_seen;

  assign popped   = m_axis_tdata[VALUE_BITS-1:0];
  assign hit      = m_axis_tdata[VALUE_BITS];
  assign refused  = m_axis_tdata[VALUE_BITS+1];
  assign is_empty = m_axis_tdata[VALUE_BITS+2];
  assign fill     = m_axis_tdata[VALUE_BITS+3+CNT_W-1:VALUE_BITS+3];
  assign in_seen  = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || s_axis_tuser != '0
                    || s_axis_tdata == '0);

  `DQDEL_ASSERT_IMP(a_empty_flag, m_axis_tvalid, is_empty == (fill == '0),
                    "empty flag disagrees with fill count")
  `DQDEL_ASSERT_IMP(a_refused_full, m_axis_tvalid && refused,
                    !hit && fill == CNT_W'(CAPACITY), "refused push while not full")
  `DQDEL_ASSERT_IMP(a_popped_hit, m_axis_tvalid && popped != '0, hit && !refused,
                    "popped value without hit")
  `DQDEL_ASSERT_NXT(a_result_follows, in_seen, m_axis_tvalid,
                    "no result after accepted beat")
  `DQDEL_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind deque_with_delete_by_value_top dqdel_checker #(
  .CAPACITY   (CAPACITY),
  .VALUE_BITS (VALUE_BITS)
) u_dqdel_checker (.*);
